/* hw/rtl/assert_macros.svh */
// assertion macros used by the rtl of the scan sequencer
// no dependencies; assumes clk_i and rst_ni are visible where used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside of reset
`define ADCSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every rising clock edge, reset included
`define ADCSS_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hw/rtl/adcss_pkg.sv */
// types and constants of the adc scan sequencer with history sums
// no dependencies
`default_nettype none

package adcss_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned CHAN_W   = 5;
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned SUM_W    = 16;
  localparam int unsigned CFG_W    = 7;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_CONVERT = 2'd1;
  localparam logic [OP_W-1:0] OP_COLLECT = 2'd2;

  localparam logic [CFG_W-1:0] LEN_RESET = 7'd1;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [SLOT_W-1:0]   slot;
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] sample;
    logic [COUNT_W-1:0]  seen_count;
  } in_req_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  next_channel;
    logic               fresh;
    logic [CHAN_W-1:0]  channel_index;
    logic [SUM_W-1:0]   channel_sum;
    logic [COUNT_W-1:0] new_count;
    logic [COUNT_W-1:0] loops;
    logic               last;
  } out_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/adcss_if.sv */
// valid/ready channel interfaces for requests into and results out of the block
// depends on adcss_pkg
`default_nettype none

interface adcss_in_if;
  import adcss_pkg::*;
  logic    valid;
  logic    ready;
  in_req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface adcss_out_if;
  import adcss_pkg::*;
  logic     valid;
  logic     ready;
  out_rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hw/rtl/adcss_ram.sv */
// simple dual port synchronous ram, one write and one read port, registered read
// no dependencies
`default_nettype none

module adcss_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                     wdata_i,
  input  wire logic                                 re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/adc_scan_sequencer_averager.sv */
// top level of the adc scan sequencer with per-channel history sums
// depends on adcss_pkg, adcss_if, adcss_ram and assert_macros.svh
//
//   port          dir  handshake           carries
//   in_i          in   valid/ready         op, slot, channel, sample, seen_count
//   out_o         out  valid/ready         next_channel .. last, one or more per convert or collect request
//   cfg_we_i      in   write enable only   pattern_length
//
// load request: written to the pattern table as it is taken, no result
// conversion: pattern read, channel state read, history read, write back,
//   pattern read at the new position, then its result
// collect: pattern and channel state read, then a single answer when the count
//   is unchanged or the channel is out of range, else one sum per channel, each
//   after its own channel state memory read
// reset: no clearing pass; per-channel valid bits make unwritten channel
//   state (and with it the history behind it) read as zero
// a new request is taken while the last result still waits in the output
//   register; a stalled output only holds the sequencer in its emit state
`default_nettype none
`include "assert_macros.svh"

module adc_scan_sequencer_averager #(
  parameter int unsigned NUM_CHANNELS  = 32,
  parameter int unsigned HIST_DEPTH    = 8,
  parameter int unsigned PATTERN_DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [adcss_pkg::CFG_W-1:0] cfg_wdata_i,
  adcss_in_if.sink                      in_i,
  adcss_out_if.source                   out_o
);

  import adcss_pkg::*;

  // address and field widths
  localparam int unsigned PatW  = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int unsigned ChW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned HistN = NUM_CHANNELS * HIST_DEPTH;
  localparam int unsigned HAW   = (HistN > 1) ? $clog2(HistN) : 1;
  localparam int unsigned HPW   = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int unsigned FW    = $clog2(HIST_DEPTH + 1);
  // channel state entry: count, ring pointer, fill level, running sum
  localparam int unsigned CEW   = COUNT_W + HPW + FW + SUM_W;
  localparam int unsigned NOut  = (NUM_CHANNELS < 32) ? NUM_CHANNELS : 32;

  localparam logic [CFG_W-1:0]  LenMax     = CFG_W'(PATTERN_DEPTH);
  localparam logic [CFG_W-1:0]  NumCh7     = CFG_W'(NUM_CHANNELS);
  localparam logic [HPW:0]      HistDepthP = (HPW + 1)'(HIST_DEPTH);
  localparam logic [FW-1:0]     HistFull   = FW'(HIST_DEPTH);
  localparam logic [CHAN_W-1:0] WalkLast   = CHAN_W'(NOut - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CV_PAT,     // pattern entry at the position arrives
    S_CV_CH,      // channel state arrives, read oldest history sample
    S_CV_UPD,     // write back history and channel state, advance position
    S_CV_NXT,     // next channel arrives, emit
    S_CL_RD,      // count of the checked channel arrives
    S_WALK_RD,    // read channel state of the walked channel
    S_WALK_EMIT   // emit its sum
  } state_e;

  state_e              state_q, state_d;
  in_req_t             req_q, req_d;
  logic [PatW-1:0]     pos_q, pos_d;
  logic [COUNT_W-1:0]  loop_q, loop_d;
  logic [CFG_W-1:0]    len_q, len_d;
  logic                cv_ok_q, cv_ok_d;
  logic                cl_ok_q, cl_ok_d;
  logic [ChW-1:0]      rd_chan_q, rd_chan_d;
  logic [HAW-1:0]      hist_addr_q, hist_addr_d;
  logic [CHAN_W-1:0]   nxt_q, nxt_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;
  logic [CHAN_W-1:0]   walk_q, walk_d;
  logic                out_valid_q, out_valid_d;
  out_rsp_t            out_q, out_d;
  logic [NUM_CHANNELS-1:0] chan_valid_q, chan_valid_d;

  // memory ports
  logic                pat_we, pat_re;
  logic [PatW-1:0]     pat_raddr;
  logic [CHAN_W-1:0]   pat_rdata;
  logic                chan_we, chan_re;
  logic [ChW-1:0]      chan_raddr;
  logic [CEW-1:0]      chan_wdata, chan_rdata, chan_ent;
  logic                hist_we, hist_re;
  logic [HAW-1:0]      hist_addr;
  logic [SAMPLE_W-1:0] hist_rdata;

  // channel state fields and their updates
  logic [COUNT_W-1:0]  e_cnt;
  logic [HPW-1:0]      e_ptr, ptr_nx;
  logic [FW-1:0]       e_fill, fill_nx;
  logic [SUM_W-1:0]    e_sum, sum_nx;
  logic [HPW:0]        ptr_inc;
  logic [SAMPLE_W-1:0] oldest;

  logic                accept, out_free, out_load;
  logic [CFG_W-1:0]    len_eff, pos_inc;
  logic                pos_wrap;
  logic [COUNT_W-1:0]  cnt_sel;

  assign in_i.ready    = (state_q == S_IDLE);
  assign accept        = in_i.valid && in_i.ready;
  assign out_free      = !out_valid_q || out_o.ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // pattern write straight from the request
  assign pat_we = accept && (in_i.payload.op == OP_LOAD) &&
                  ({1'b0, in_i.payload.slot} < LenMax);

  // an unwritten channel reads as all zero
  assign chan_ent = chan_valid_q[rd_chan_q] ? chan_rdata : '0;
  assign {e_cnt, e_ptr, e_fill, e_sum} = chan_ent;

  assign ptr_inc   = {1'b0, e_ptr} + (HPW + 1)'(1);
  assign ptr_nx    = (ptr_inc == HistDepthP) ? '0 : ptr_inc[HPW-1:0];
  assign fill_nx   = (e_fill == HistFull) ? e_fill : e_fill + FW'(1);
  // before the ring is full the dropped sample is a reset zero
  assign oldest    = (e_fill == HistFull) ? hist_rdata : '0;
  assign sum_nx    = e_sum - SUM_W'(oldest) + SUM_W'(req_q.sample);
  assign chan_wdata = {e_cnt + COUNT_W'(1), ptr_nx, fill_nx, sum_nx};
  assign hist_addr = HAW'(rd_chan_q) * HAW'(HIST_DEPTH) + HAW'(e_ptr);

  // effective length and position advance
  always_comb begin
    priority if (len_q == '0) begin
      len_eff = CFG_W'(1);
    end else if (len_q > LenMax) begin
      len_eff = LenMax;
    end else begin
      len_eff = len_q;
    end
  end
  assign pos_inc  = CFG_W'(pos_q) + CFG_W'(1);
  assign pos_wrap = (pos_inc >= len_eff);

  assign cnt_sel = cl_ok_q ? e_cnt : '0;

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    pos_d        = pos_q;
    loop_d       = loop_q;
    len_d        = cfg_we_i ? cfg_wdata_i : len_q;
    cv_ok_d      = cv_ok_q;
    cl_ok_d      = cl_ok_q;
    hist_addr_d  = hist_addr_q;
    nxt_d        = nxt_q;
    cnt_d        = cnt_q;
    walk_d       = walk_q;
    out_d        = out_q;
    out_load     = 1'b0;
    chan_valid_d = chan_valid_q;
    pat_re       = 1'b0;
    pat_raddr    = pos_q;
    chan_re      = 1'b0;
    chan_raddr   = rd_chan_q;
    chan_we      = 1'b0;
    hist_re      = 1'b0;
    hist_we      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d = in_i.payload;
          priority if (in_i.payload.op == OP_CONVERT) begin
            pat_re  = 1'b1;
            state_d = S_CV_PAT;
          end else if (in_i.payload.op == OP_COLLECT) begin
            pat_re     = 1'b1;
            chan_re    = 1'b1;
            chan_raddr = ChW'(in_i.payload.channel);
            cl_ok_d    = ({2'b00, in_i.payload.channel} < NumCh7);
            state_d    = S_CL_RD;
          end else begin
            // pattern load finishes here, unused op is dropped
            state_d = S_IDLE;
          end
        end
      end
      S_CV_PAT: begin
        chan_re    = 1'b1;
        chan_raddr = ChW'(pat_rdata);
        cv_ok_d    = ({2'b00, pat_rdata} < NumCh7);
        state_d    = S_CV_CH;
      end
      S_CV_CH: begin
        hist_re     = 1'b1;
        hist_addr_d = hist_addr;
        state_d     = S_CV_UPD;
      end
      S_CV_UPD: begin
        // out-of-range channel drops the sample but still advances
        hist_we = cv_ok_q;
        chan_we = cv_ok_q;
        if (cv_ok_q) begin
          chan_valid_d[rd_chan_q] = 1'b1;
        end
        pos_d  = pos_wrap ? '0 : PatW'(pos_inc);
        loop_d = pos_wrap ? loop_q + COUNT_W'(1) : loop_q;
        pat_re    = 1'b1;
        pat_raddr = pos_d;
        state_d   = S_CV_NXT;
      end
      S_CV_NXT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = '{next_channel: pat_rdata, fresh: 1'b0, channel_index: '0,
                       channel_sum: '0, new_count: '0, loops: loop_q, last: 1'b1};
          state_d  = S_IDLE;
        end
      end
      S_CL_RD: begin
        nxt_d = pat_rdata;
        cnt_d = cnt_sel;
        if (!cl_ok_q || (cnt_sel == req_q.seen_count)) begin
          if (out_free) begin
            out_load = 1'b1;
            out_d    = '{next_channel: pat_rdata, fresh: 1'b0, channel_index: '0,
                         channel_sum: '0, new_count: cnt_sel, loops: loop_q,
                         last: 1'b1};
            state_d  = S_IDLE;
          end
        end else begin
          walk_d  = '0;
          state_d = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        chan_re    = 1'b1;
        chan_raddr = ChW'(walk_q);
        state_d    = S_WALK_EMIT;
      end
      S_WALK_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = '{next_channel: nxt_q, fresh: 1'b1, channel_index: walk_q,
                       channel_sum: e_sum, new_count: cnt_q, loops: loop_q,
                       last: (walk_q == WalkLast)};
          if (walk_q == WalkLast) begin
            state_d = S_IDLE;
          end else begin
            walk_d  = walk_q + CHAN_W'(1);
            state_d = S_WALK_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    rd_chan_d   = chan_re ? chan_raddr : rd_chan_q;
    out_valid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      req_q        <= '0;
      pos_q        <= '0;
      loop_q       <= '0;
      len_q        <= LEN_RESET;
      cv_ok_q      <= 1'b0;
      cl_ok_q      <= 1'b0;
      rd_chan_q    <= '0;
      hist_addr_q  <= '0;
      nxt_q        <= '0;
      cnt_q        <= '0;
      walk_q       <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      chan_valid_q <= '0;
    end else begin
      state_q      <= state_d;
      req_q        <= req_d;
      pos_q        <= pos_d;
      loop_q       <= loop_d;
      len_q        <= len_d;
      cv_ok_q      <= cv_ok_d;
      cl_ok_q      <= cl_ok_d;
      rd_chan_q    <= rd_chan_d;
      hist_addr_q  <= hist_addr_d;
      nxt_q        <= nxt_d;
      cnt_q        <= cnt_d;
      walk_q       <= walk_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
      chan_valid_q <= chan_valid_d;
    end
  end

  // scan pattern table
  adcss_ram #(
    .Width (CHAN_W),
    .Depth (PATTERN_DEPTH)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (PatW'(in_i.payload.slot)),
    .wdata_i (in_i.payload.channel),
    .re_i    (pat_re),
    .raddr_i (pat_raddr),
    .rdata_o (pat_rdata)
  );

  // per-channel count, ring pointer, fill level and running sum
  adcss_ram #(
    .Width (CEW),
    .Depth (NUM_CHANNELS)
  ) u_chan_ram (
    .clk_i   (clk_i),
    .we_i    (chan_we),
    .waddr_i (rd_chan_q),
    .wdata_i (chan_wdata),
    .re_i    (chan_re),
    .raddr_i (chan_raddr),
    .rdata_o (chan_rdata)
  );

  // sample history rings, one per channel
  adcss_ram #(
    .Width (SAMPLE_W),
    .Depth (HistN)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_addr_q),
    .wdata_i (req_q.sample),
    .re_i    (hist_re),
    .raddr_i (hist_addr),
    .rdata_o (hist_rdata)
  );

  `ADCSS_ASSERT_NR(pos_in_range_a, CFG_W'(pos_q) < LenMax, "pattern position out of range")
  `ADCSS_ASSERT(chan_wr_in_range_a, chan_we |-> (cv_ok_q && (CFG_W'(rd_chan_q) < NumCh7)),
                "channel state write out of range")
  `ADCSS_ASSERT(loop_only_on_wrap_a, (loop_q != $past(loop_q)) |-> (pos_q == '0),
                "loop count moved without wrap")
  `ADCSS_ASSERT(last_ends_request_a, (out_load && out_d.last) |=> (state_q == S_IDLE),
                "final result did not end the request")

endmodule

`default_nettype wire

/* tb/tb.sv */
// self-checking testbench for adc_scan_sequencer_averager: scan pattern loads, conversions,
// collect queries and pattern length writes, checked against a state mirror in a small class
// depends on adcss_pkg, adcss_if and the rtl of the block
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import adcss_pkg::*;

  localparam int unsigned CHANNELS        = 32;
  localparam int unsigned HIST            = 8;
  localparam int unsigned SLOTS           = 64;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 45;
  // settle time after the owed results, so this covers a load or an unused op still in flight
  localparam int unsigned SETTLE_CYCLES   = 12;
  // longest stretch without any request or result moving before the run is abandoned
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned REPORT_LIMIT    = 10;

  // the fourth op code is not defined by the block and must be dropped silently
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef enum int unsigned {
    PACE_FULL,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH
  } pace_e;

  // mirror of the sequencer state, updated when a request is taken,
  // plus the queue of results still owed by the block
  class scan_mirror;
    logic [CHAN_W-1:0]   pattern [SLOTS];
    logic [SAMPLE_W-1:0] history [CHANNELS][HIST];
    logic [COUNT_W-1:0]  counts  [CHANNELS];
    logic [SLOT_W-1:0]   position;
    logic [COUNT_W-1:0]  loops;
    logic [CFG_W-1:0]    length;
    out_rsp_t            results_due[$];
    int unsigned         mismatch_count;

    function new();
      foreach (pattern[i]) pattern[i] = '0;
      foreach (history[c, d]) history[c][d] = '0;
      foreach (counts[c]) counts[c] = '0;
      position       = '0;
      loops          = '0;
      length         = LEN_RESET;
      mismatch_count = 0;
    endfunction

    function void take_request(in_req_t req);
      out_rsp_t          rsp;
      logic [CHAN_W-1:0] ch;
      logic [SUM_W-1:0]  sum;
      int unsigned       span;
      int unsigned       next_pos;
      rsp = '0;
      case (req.op)
        OP_LOAD: pattern[req.slot] = req.channel;
        OP_CONVERT: begin
          // newest sample enters at the top, oldest falls off the bottom
          ch = pattern[position];
          for (int d = 0; d < HIST - 1; d++) history[ch][d] = history[ch][d + 1];
          history[ch][HIST - 1] = req.sample;
          counts[ch] = counts[ch] + 1'b1;
          // zero length acts as one, anything past the table as the table size
          span = (length == 0) ? 1 : ((length > SLOTS) ? SLOTS : length);
          // a position already past a shortened length wraps on the next step
          next_pos = position + 1;
          if (next_pos >= span) begin
            next_pos = 0;
            loops    = loops + 1'b1;
          end
          position         = next_pos[SLOT_W-1:0];
          rsp.next_channel = pattern[position];
          rsp.loops        = loops;
          rsp.last         = 1'b1;
          results_due.push_back(rsp);
        end
        OP_COLLECT: begin
          rsp.next_channel = pattern[position];
          rsp.loops        = loops;
          rsp.new_count    = counts[req.channel];
          if (counts[req.channel] == req.seen_count) begin
            rsp.last = 1'b1;
            results_due.push_back(rsp);
          end else begin
            // count moved: every channel's history sum, in channel order
            for (int c = 0; c < CHANNELS; c++) begin
              sum = '0;
              for (int d = 0; d < HIST; d++) sum = sum + SUM_W'(history[c][d]);
              rsp.fresh         = 1'b1;
              rsp.channel_index = CHAN_W'(c);
              rsp.channel_sum   = sum;
              rsp.last          = (c == CHANNELS - 1);
              results_due.push_back(rsp);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function string show(out_rsp_t r);
      return $sformatf("next=%0d fresh=%0d ch=%0d sum=%0d count=%0d loops=%0d last=%0d",
                       r.next_channel, r.fresh, r.channel_index, r.channel_sum,
                       r.new_count, r.loops, r.last);
    endfunction

    function void match_result(out_rsp_t got);
      out_rsp_t want;
      bit       bad;
      if (results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: result with nothing outstanding: %s", $realtime, show(got));
      end else begin
        want = results_due.pop_front();
        bad  = (got.next_channel  !== want.next_channel)  ||
               (got.fresh         !== want.fresh)         ||
               (got.channel_index !== want.channel_index) ||
               (got.channel_sum   !== want.channel_sum)   ||
               (got.new_count     !== want.new_count)     ||
               (got.loops         !== want.loops)         ||
               (got.last          !== want.last);
        if (bad) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result mismatch\n  want %s\n  got  %s",
                     $realtime, show(want), show(got));
        end
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  adcss_in_if  req_if ();
  adcss_out_if rsp_if ();

  adc_scan_sequencer_averager u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (req_if),
    .out_o       (rsp_if)
  );

  scan_mirror mirror;
  pace_e      pace = PACE_FULL;

  // 20 ns clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned sender_idle_pct();
    case (pace)
      PACE_SENDER_IDLE: return 84;
      PACE_BOTH:        return 8;
      default:          return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_stall_pct();
    case (pace)
      PACE_RECEIVER_STALL: return 84;
      PACE_BOTH:           return 8;
      default:             return 0;
    endcase
  endfunction

  function automatic in_req_t make_request(logic [OP_W-1:0] op, int unsigned slot,
                                           int unsigned channel, int unsigned sample,
                                           int unsigned seen);
    in_req_t req;
    req.op         = op;
    req.slot       = SLOT_W'(slot);
    req.channel    = CHAN_W'(channel);
    req.sample     = SAMPLE_W'(sample);
    req.seen_count = COUNT_W'(seen);
    return req;
  endfunction

  // mostly conversions and collects, with pattern rewrites and the odd unused op
  function automatic in_req_t random_request();
    in_req_t     req;
    int unsigned pick;
    req = make_request(OP_LOAD, $urandom_range(SLOTS - 1), $urandom_range(CHANNELS - 1),
                       $urandom_range(1023), $urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 50) begin
      req.op = OP_CONVERT;
      // full-scale and zero samples show up often
      case ($urandom_range(9))
        0:       req.sample = '0;
        1:       req.sample = '1;
        default: ;
      endcase
    end else if (pick < 72) begin
      req.op = OP_COLLECT;
      // half the queries ask with the current count so the quiet answer is common
      case ($urandom_range(3))
        0, 1:    req.seen_count = mirror.counts[req.channel];
        2:       req.seen_count = mirror.counts[req.channel] - 1'b1;
        default: ;
      endcase
    end else if (pick >= 92) begin
      req.op = OP_UNUSED;
    end
    return req;
  endfunction

  // holds valid high until the request is taken; valid is only lowered
  // when the sender decides to idle, so back-to-back requests keep it high
  task automatic send_request(in_req_t req);
    while ($urandom_range(99) < sender_idle_pct()) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= req;
    do @(posedge clk_i); while (!req_if.ready);
    mirror.take_request(req);
  endtask

  // stop sending, wait for every owed result, then let a silent request finish
  task automatic drain();
    req_if.valid <= 1'b0;
    while (mirror.results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // only called with the block idle
  task automatic write_length(logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    mirror.length = value;
    cfg_we_i <= 1'b0;
  endtask

  // result side: check on every accepted result, then pick the next ready
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) mirror.match_result(rsp_if.payload);
      rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct());
    end
  end

  // watchdog on cycles where nothing moves on either channel
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int unsigned      counted;
    in_req_t          req;
    logic [CFG_W-1:0] len;
    mirror = new();
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    rst_ni         <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the whole pattern so no conversion or collect ever reads an unwritten slot;
    // first and last slots carry the lowest and highest channel
    for (int s = 0; s < SLOTS; s++)
      send_request(make_request(OP_LOAD, s,
                                (s == 0) ? 0 : ((s == SLOTS - 1) ? CHANNELS - 1
                                                                 : $urandom_range(CHANNELS - 1)),
                                0, 0));

    // directed: reset length of one, so every conversion lands on slot 0 (channel 0)
    send_request(make_request(OP_COLLECT, 0, 0, 0, 0));            // count unchanged
    send_request(make_request(OP_CONVERT, 0, 0, 1023, 0));         // full-scale sample
    send_request(make_request(OP_CONVERT, 63, 31, 0, 255));        // zero sample
    send_request(make_request(OP_COLLECT, 0, 0, 0, 0));            // count moved, all sums
    send_request(make_request(OP_COLLECT, 63, 31, 1023, 255));     // top channel, top seen
    send_request(make_request(OP_COLLECT, 0, 0, 0, 2));            // caught up again
    send_request(make_request(OP_UNUSED, 63, 31, 1023, 255));      // unused op, dropped
    send_request(make_request(OP_LOAD, 63, 31, 1023, 255));        // last slot rewritten
    drain();

    // walk deep into a long pattern, then shorten it under the current position
    write_length(7'd64);
    for (int i = 0; i < 10; i++)
      send_request(make_request(OP_CONVERT, 0, 0, (i % 2) ? 1023 : $urandom_range(1023), 0));
    drain();
    write_length(7'd3);
    send_request(make_request(OP_CONVERT, 0, 0, 512, 0));          // wraps past short length
    send_request(make_request(OP_CONVERT, 0, 0, 1, 0));
    drain();

    // random phases, each with its own pattern length and handshake pace
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       len = 7'd64;
        1:       len = 7'd0;
        2:       len = 7'd127;
        3:       len = 7'd5;
        4:       len = 7'd1;
        5:       len = CFG_W'($urandom_range(1, 64));
        6:       len = 7'd40;
        default: len = 7'd2;
      endcase
      write_length(len);
      pace = pace_e'(p % 4);
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        req = random_request();
        send_request(req);
        if (req.op != OP_UNUSED) counted++;
      end
      drain();
    end

    if (mirror.mismatch_count == 0 && mirror.results_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
